// ===== sv/cts_pkg.sv =====
// Shared types and codes of the cooperative thread scheduler.
package cts_pkg;

	localparam int MAX_THREADS_DEF = 16;

	localparam logic [2:0] MODE_REGISTER = 3'd0;
	localparam logic [2:0] MODE_START    = 3'd1;
	localparam logic [2:0] MODE_YIELD    = 3'd2;
	localparam logic [2:0] MODE_BUSY     = 3'd3;
	localparam logic [2:0] MODE_FINISH   = 3'd4;
	localparam logic [2:0] MODE_KILL     = 3'd5;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_POOL_FULL   = 3'd1;
	localparam logic [2:0] ST_ALREADY     = 3'd2;
	localparam logic [2:0] ST_NO_THREADS  = 3'd3;
	localparam logic [2:0] ST_NOT_RUNNING = 3'd4;
	localparam logic [2:0] ST_ALL_DONE    = 3'd5;

	localparam logic [15:0] RESUME_ENTRY = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] module_id;
		logic [15:0] entry_address;
		logic [15:0] entry_number;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        dispatch_valid;
		logic [15:0] dispatch_address;
		logic [15:0] dispatch_entry;
		logic [15:0] current_thread;
	} result_t;

endpackage

// ===== sv/cooperative_thread_scheduler_unit.sv =====
// Top level of the cooperative round-robin thread scheduler.
// Each request word (register, start, yield, busy, finish, kill) gives exactly one
// response word. A request is captured in an input register, evaluated against the
// thread pool and ready ring in one combinational pass, and the response lands in
// an output register; one request is taken every cycle while the response side
// keeps up. The thread id of a slot is its index plus one, since slots are never
// freed after reset.
module cooperative_thread_scheduler_unit #(
	parameter int MAX_THREADS = cts_pkg::MAX_THREADS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  mode,
	input  logic [15:0] module_id,
	input  logic [15:0] entry_address,
	input  logic [15:0] entry_number,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic        dispatch_valid,
	output logic [15:0] dispatch_address,
	output logic [15:0] dispatch_entry,
	output logic [15:0] current_thread
);
	import cts_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_q;
	logic    rsp_valid_q;
	logic    advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= '{mode: mode, module_id: module_id,
				entry_address: entry_address, entry_number: entry_number};
		end
		if (advance) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	cts_core #(
		.MAX_THREADS(MAX_THREADS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.result (res_c)
	);

	assign rsp_valid        = rsp_valid_q;
	assign status           = res_q.status;
	assign dispatch_valid   = res_q.dispatch_valid;
	assign dispatch_address = res_q.dispatch_address;
	assign dispatch_entry   = res_q.dispatch_entry;
	assign current_thread   = res_q.current_thread;

endmodule

// ===== sv/cts_core.sv =====
// Scheduler state (thread pool, ready ring) and the single-pass step logic.
module cts_core #(
	parameter int MAX_THREADS = cts_pkg::MAX_THREADS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            commit,
	input  cts_pkg::item_t  item,
	output cts_pkg::result_t result
);
	import cts_pkg::*;

	localparam int IDX_W = $clog2(MAX_THREADS);
	localparam int CNT_W = $clog2(MAX_THREADS + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_THREADS);
	localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_THREADS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_THREADS - 1);

	logic [IDX_W-1:0] ring_q [MAX_THREADS];
	logic [15:0]      addr_q [MAX_THREADS];
	logic [15:0]      entry_q [MAX_THREADS];

	logic [IDX_W-1:0] head_q, head_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [CNT_W-1:0] used_q, used_n;
	logic             active_q, active_n;
	logic [IDX_W-1:0] cur_slot_q, cur_slot_n;
	logic             cur_valid_q, cur_valid_n;

	logic             wr_en;
	logic [IDX_W-1:0] wr_slot;
	logic [15:0]      wr_addr, wr_entry;
	logic             push_en, push_ok, pop_en, pop_ok;
	logic [IDX_W-1:0] push_slot, pop_slot;
	logic [SUM_W-1:0] tail_sum, tail_wrap;
	logic [IDX_W-1:0] tail_idx;
	logic [CNT_W-1:0] count_pushed;
	logic             active_cur;

	assign active_cur = active_q && cur_valid_q;
	assign tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_wrap  = (tail_sum >= MAX_SUM) ? tail_sum - MAX_SUM : tail_sum;
	assign tail_idx   = tail_wrap[IDX_W-1:0];

	always_comb begin
		result.status           = ST_OK;
		result.dispatch_valid   = 1'b0;
		result.dispatch_address = '0;
		result.dispatch_entry   = '0;
		wr_en     = 1'b0;
		wr_slot   = cur_slot_q;
		wr_addr   = item.entry_address;
		wr_entry  = RESUME_ENTRY;
		push_en   = 1'b0;
		push_slot = cur_slot_q;
		pop_en    = 1'b0;
		used_n    = used_q;
		active_n  = active_q;
		case (item.mode)
			MODE_REGISTER: begin
				if (used_q >= MAX_CNT) begin
					result.status = ST_POOL_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_slot   = used_q[IDX_W-1:0];
					wr_entry  = item.entry_number;
					push_en   = 1'b1;
					push_slot = used_q[IDX_W-1:0];
					used_n    = used_q + 1'b1;
				end
			end
			MODE_START: begin
				if (active_q) begin
					result.status = ST_ALREADY;
				end else if (count_q == '0) begin
					result.status = ST_NO_THREADS;
				end else begin
					pop_en   = 1'b1;
					active_n = 1'b1;
				end
			end
			MODE_YIELD: begin
				if (!active_cur) begin
					result.dispatch_valid   = 1'b1;
					result.dispatch_address = item.entry_address;
					result.dispatch_entry   = RESUME_ENTRY;
				end else begin
					wr_en   = 1'b1;
					push_en = 1'b1;
					pop_en  = 1'b1;
				end
			end
			MODE_BUSY: begin
				if (!active_cur) begin
					result.status = ST_NOT_RUNNING;
				end else begin
					push_en = 1'b1;
					pop_en  = 1'b1;
				end
			end
			MODE_FINISH, MODE_KILL: begin
				if (!active_cur) begin
					result.status = ST_NOT_RUNNING;
				end else if (count_q == '0) begin
					result.status = ST_ALL_DONE;
					active_n      = 1'b0;
				end else begin
					pop_en = 1'b1;
				end
			end
			default: begin
			end
		endcase

		push_ok      = push_en && (count_q < MAX_CNT);
		count_pushed = count_q + CNT_W'(push_ok);
		pop_ok       = pop_en && (count_pushed != '0);
		pop_slot     = (count_q == '0 && push_ok) ? push_slot : ring_q[head_q];

		head_n      = head_q;
		count_n     = count_pushed;
		cur_slot_n  = cur_slot_q;
		cur_valid_n = cur_valid_q;
		if (pop_ok) begin
			head_n      = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			count_n     = count_pushed - 1'b1;
			cur_slot_n  = pop_slot;
			cur_valid_n = 1'b1;
			result.dispatch_valid = 1'b1;
			if (wr_en && wr_slot == pop_slot) begin
				result.dispatch_address = wr_addr;
				result.dispatch_entry   = wr_entry;
			end else begin
				result.dispatch_address = addr_q[pop_slot];
				result.dispatch_entry   = entry_q[pop_slot];
			end
		end
		if (result.status == ST_ALL_DONE) begin
			cur_slot_n  = '0;
			cur_valid_n = 1'b0;
		end
		result.current_thread = cur_valid_n ? 16'(cur_slot_n) + 16'd1 : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			addr_q[wr_slot]  <= wr_addr;
			entry_q[wr_slot] <= wr_entry;
		end
		if (commit && push_ok) begin
			ring_q[tail_idx] <= push_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			used_q      <= '0;
			active_q    <= 1'b0;
			cur_slot_q  <= '0;
			cur_valid_q <= 1'b0;
		end else if (commit) begin
			head_q      <= head_n;
			count_q     <= count_n;
			used_q      <= used_n;
			active_q    <= active_n;
			cur_slot_q  <= cur_slot_n;
			cur_valid_q <= cur_valid_n;
		end
	end

endmodule

// ===== bench/tb_cooperative_thread_scheduler_unit.sv =====
// Testbench for the cooperative thread scheduler: directed table, then random words vs predictor.
module tb_cooperative_thread_scheduler_unit;
	import cts_pkg::*;

	localparam int POOL = MAX_THREADS_DEF;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int RANDOM_WORDS = 1200;
	localparam int DRAIN_EVERY = 300;
	localparam int TAIL_CYCLES = 8;
	localparam int STALL_LIMIT = 400;

	typedef struct packed {
		item_t   word;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [2:0]  mode = '0;
	logic [15:0] module_id = '0;
	logic [15:0] entry_address = '0;
	logic [15:0] entry_number = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [2:0]  status;
	logic        dispatch_valid;
	logic [15:0] dispatch_address;
	logic [15:0] dispatch_entry;
	logic [15:0] current_thread;

	cooperative_thread_scheduler_unit u_top (.*);

	// predictor state
	logic [15:0] tcb_id    [POOL];
	logic [15:0] tcb_addr  [POOL];
	logic [15:0] tcb_entry [POOL];
	int          ring_slot [POOL];
	int          ring_head = 0;
	int          ring_count = 0;
	int          pool_used = 0;
	logic [15:0] id_next = 16'd1;
	bit          sched_on = 1'b0;
	bit          cur_valid = 1'b0;
	int          cur_slot = 0;

	result_t     expected_rsp [$];
	dir_row_t    dir_rows [$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          calm_tx = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void requeue(int s);
		if (ring_count < POOL) begin
			ring_slot[(ring_head + ring_count) % POOL] = s;
			ring_count++;
		end
	endfunction

	function automatic bit pick_next(inout result_t r);
		int s;
		if (ring_count == 0)
			return 1'b0;
		s = ring_slot[ring_head];
		ring_head = (ring_head + 1) % POOL;
		ring_count--;
		cur_slot = s;
		cur_valid = 1'b1;
		r.dispatch_valid = 1'b1;
		r.dispatch_address = tcb_addr[s];
		r.dispatch_entry = tcb_entry[s];
		return 1'b1;
	endfunction

	function automatic result_t schedule_step(item_t w);
		result_t r;
		r = '0;
		case (w.mode)
			MODE_REGISTER: begin
				if (pool_used >= POOL) begin
					r.status = ST_POOL_FULL;
				end else begin
					tcb_id[pool_used] = id_next;
					tcb_addr[pool_used] = w.entry_address;
					tcb_entry[pool_used] = w.entry_number;
					id_next = id_next + 16'd1;
					requeue(pool_used);
					pool_used++;
				end
			end
			MODE_START: begin
				if (sched_on)
					r.status = ST_ALREADY;
				else if (pick_next(r))
					sched_on = 1'b1;
				else
					r.status = ST_NO_THREADS;
			end
			MODE_YIELD: begin
				if (!sched_on || !cur_valid) begin
					r.dispatch_valid = 1'b1;
					r.dispatch_address = w.entry_address;
					r.dispatch_entry = RESUME_ENTRY;
				end else begin
					tcb_addr[cur_slot] = w.entry_address;
					tcb_entry[cur_slot] = RESUME_ENTRY;
					requeue(cur_slot);
					void'(pick_next(r));
				end
			end
			MODE_BUSY: begin
				if (!sched_on || !cur_valid) begin
					r.status = ST_NOT_RUNNING;
				end else begin
					requeue(cur_slot);
					void'(pick_next(r));
				end
			end
			MODE_FINISH, MODE_KILL: begin
				if (!sched_on || !cur_valid) begin
					r.status = ST_NOT_RUNNING;
				end else if (!pick_next(r)) begin
					r.status = ST_ALL_DONE;
					sched_on = 1'b0;
					cur_valid = 1'b0;
					cur_slot = 0;
				end
			end
			default: ;
		endcase
		r.current_thread = cur_valid ? tcb_id[cur_slot] : 16'd0;
		return r;
	endfunction

	function automatic result_t want(logic [2:0] st, logic dv, logic [15:0] a, logic [15:0] e,
			logic [15:0] t);
		result_t r;
		r.status = st;
		r.dispatch_valid = dv;
		r.dispatch_address = a;
		r.dispatch_entry = e;
		r.current_thread = t;
		return r;
	endfunction

	task automatic add_row(logic [2:0] m, logic [15:0] mid, logic [15:0] ea, logic [15:0] en,
			logic typed, result_t r);
		dir_row_t row;
		row.word.mode = m;
		row.word.module_id = mid;
		row.word.entry_address = ea;
		row.word.entry_number = en;
		row.typed = typed;
		row.want = r;
		dir_rows.push_back(row);
	endtask

	// mostly well-formed traffic while threads live; retirement kept rare
	function automatic item_t draw_request();
		item_t w;
		int r;
		w.module_id = 16'($urandom);
		w.entry_address = 16'($urandom);
		w.entry_number = 16'($urandom);
		r = $urandom_range(0, 999);
		if (!sched_on) begin
			if (ring_count > 0 && r < 600)
				w.mode = MODE_START;
			else if (r < 750)
				w.mode = MODE_REGISTER;
			else
				w.mode = 3'($urandom_range(0, 7));
		end else if (r < 80) begin
			w.mode = MODE_REGISTER;
		end else if (r < 110) begin
			w.mode = MODE_START;
		end else if (r < 520) begin
			w.mode = MODE_YIELD;
		end else if (r < 930) begin
			w.mode = MODE_BUSY;
		end else if (r < 934) begin
			w.mode = MODE_FINISH;
		end else if (r < 938) begin
			w.mode = MODE_KILL;
		end else if (r < 970) begin
			w.mode = MODE_YIELD;
		end else begin
			w.mode = 3'($urandom_range(0, 7));
		end
		return w;
	endfunction

	task automatic send_word(item_t w, logic typed, result_t fixed, bit drain);
		int gap;
		result_t exp_r;
		if ($urandom_range(0, 15) == 0)
			calm_tx = !calm_tx;
		gap = calm_tx ? 0 : $urandom_range(0, 13);
		if (drain && gap == 0)
			gap = 1;
		if (gap > 0) begin
			req_valid <= 1'b0;
			while (drain && expected_rsp.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= w.mode;
		module_id <= w.module_id;
		entry_address <= w.entry_address;
		entry_number <= w.entry_number;
		do @(posedge clk); while (!req_ready);
		exp_r = schedule_step(w);
		expected_rsp.push_back(typed ? fixed : exp_r);
	endtask

	task automatic check_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %h actual %h", $time, what, exp_v, got_v);
			errors++;
		end
	endtask

	task automatic check_rsp();
		result_t exp_r;
		if (expected_rsp.size() == 0) begin
			$display("%0t: unexpected response word, expected none actual status %0d thread %h",
				$time, status, current_thread);
			errors++;
		end else begin
			exp_r = expected_rsp.pop_front();
			check_field("status", 16'(exp_r.status), 16'(status));
			check_field("dispatch_valid", 16'(exp_r.dispatch_valid), 16'(dispatch_valid));
			check_field("dispatch_address", exp_r.dispatch_address, dispatch_address);
			check_field("dispatch_entry", exp_r.dispatch_entry, dispatch_entry);
			check_field("current_thread", exp_r.current_thread, current_thread);
		end
	endtask

	initial begin
		int stall;
		bit calm;
		calm = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			check_rsp();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		add_row(MODE_START, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_NO_THREADS, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_BUSY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			want(ST_NOT_RUNNING, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_FINISH, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_NOT_RUNNING, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_KILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			want(ST_NOT_RUNNING, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_YIELD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			want(ST_OK, 1'b1, 16'hFFFF, RESUME_ENTRY, 16'h0));
		add_row(MODE_YIELD, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_OK, 1'b1, 16'h0000, RESUME_ENTRY, 16'h0));
		add_row(MODE_SPARE6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			want(ST_OK, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_SPARE7, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_OK, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_REGISTER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			want(ST_OK, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_START, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_OK, 1'b1, 16'hFFFF, 16'hFFFF, 16'd1));
		add_row(MODE_START, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_ALREADY, 1'b0, 16'h0, 16'h0, 16'd1));
		add_row(MODE_FINISH, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_ALL_DONE, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_START, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_NO_THREADS, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_REGISTER, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_OK, 1'b0, 16'h0, 16'h0, 16'h0));
		add_row(MODE_REGISTER, 16'hA5A5, 16'h5A5A, 16'h1234, 1'b0, '0);
		add_row(MODE_START, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			want(ST_OK, 1'b1, 16'h0000, 16'h0000, 16'd2));
		add_row(MODE_REGISTER, 16'h3C3C, 16'hC3C3, 16'h7FFF, 1'b0, '0);
		add_row(MODE_YIELD, 16'h1111, 16'h8000, 16'h0000, 1'b0, '0);
		add_row(MODE_BUSY, 16'h2222, 16'h0000, 16'h0000, 1'b0, '0);
		add_row(MODE_YIELD, 16'h3333, 16'h0001, 16'h0000, 1'b0, '0);
		add_row(MODE_KILL, 16'hBEEF, 16'h0000, 16'h0000, 1'b0, '0);
		add_row(MODE_BUSY, 16'h4444, 16'h0000, 16'h0000, 1'b0, '0);
		add_row(MODE_FINISH, 16'h5555, 16'h0000, 16'h0000, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want, 1'b0);
		for (int n = 0; n < RANDOM_WORDS; n++)
			send_word(draw_request(), 1'b0, '0, (n % DRAIN_EVERY) == 0);
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== cooperative_thread_scheduler_unit.f =====
sv/cts_pkg.sv
sv/cts_core.sv
sv/cooperative_thread_scheduler_unit.sv
bench/tb_cooperative_thread_scheduler_unit.sv
